/* rtl/core/gspd_pkg.sv */
// Shared types and constants for the grid shortest path search block.
`timescale 1ns / 1ps
`default_nettype none
package gspd_pkg;

   // Distance word: 30-bit saturated sums plus one code for "not reached".
   localparam int DIST_W = 31;
   localparam logic [DIST_W-1:0] DIST_SAT = 31'h3FFF_FFFF;
   localparam logic [DIST_W-1:0] DIST_INF = 31'h7FFF_FFFF;

   // Grid dimensions are 8-bit registers clamped against a maximum of up to 256.
   localparam int DIM_W = 9;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_NUM_ROWS  = 3'd0,
      CSR_NUM_COLS  = 3'd1,
      CSR_START_ROW = 3'd2,
      CSR_START_COL = 3'd3,
      CSR_END_ROW   = 3'd4,
      CSR_END_COL   = 3'd5,
      CSR_DIR_MASK  = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_CLEAR,
      S_INIT0,
      S_INIT1,
      S_SWEEP,
      S_GOAL0,
      S_GOAL1,
      S_DONE
   } state_type;

   // Sweep sequence: issue own read, four neighbor reads, then write back.
   localparam logic [2:0] STEP_OWN  = 3'd0;
   localparam logic [2:0] STEP_LAST = 3'd5;

endpackage
`default_nettype wire

/* rtl/core/grid_shortest_path_dijkstra.sv */
// Top level of the grid shortest path search: cell loading, search sequencer, result port.
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/tready     tdata: cell_cost[15:0]; tuser: last
// rsp      out        rsp_tvalid/tready     tdata: path_sum[29:0]; tuser: unreachable
// csr      in         csr_we (no wait)      csr_addr register index, csr_wdata value
//
// Cells load at one transaction per cycle. A last transaction starts the search and
// drops req_tready until the result is registered. The search clears rows*cols distance
// entries (one per cycle), then relaxes cells in alternating forward and backward sweeps
// (own read, four neighbor reads, write back per cell) through the single distance RAM
// read port and one shared saturating add/compare until a sweep changes nothing; then the
// goal is read. Reset is synchronous, active high, and restores the register defaults.
// A waiting result holds in the rsp register; loading of the next grid goes on meanwhile.
module grid_shortest_path_dijkstra #(
   parameter int MAX_ROWS  = 128,
   parameter int MAX_COLS  = 128,
   parameter int COST_BITS = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [15:0]                        req_tdata,  // cell_cost[15:0]
   input  wire [0:0]                         req_tuser,  // last
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [31:0]                       rsp_tdata,  // path_sum[29:0], zero fill
   output logic [0:0]                        rsp_tuser,  // unreachable
   input  wire                               csr_we,
   input  wire [gspd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire [gspd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gspd_pkg::*;

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int CB    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam logic [CB-1:0] LAST_CELL = CB'(CELLS - 1);

   // configuration registers
   logic [7:0] num_rows_ff, num_cols_ff;
   logic [6:0] start_row_ff, start_col_ff, end_row_ff, end_col_ff;
   logic [3:0] dir_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff  <= 8'd128;
         num_cols_ff  <= 8'd128;
         start_row_ff <= 7'd0;
         start_col_ff <= 7'd0;
         end_row_ff   <= 7'd127;
         end_col_ff   <= 7'd127;
         dir_mask_ff  <= 4'hF;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_NUM_ROWS:  num_rows_ff  <= csr_wdata;
            CSR_NUM_COLS:  num_cols_ff  <= csr_wdata;
            CSR_START_ROW: start_row_ff <= csr_wdata[6:0];
            CSR_START_COL: start_col_ff <= csr_wdata[6:0];
            CSR_END_ROW:   end_row_ff   <= csr_wdata[6:0];
            CSR_END_COL:   end_col_ff   <= csr_wdata[6:0];
            CSR_DIR_MASK:  dir_mask_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // state and datapath registers
   state_type state_ff, state_in;
   logic [CB-1:0]        load_ff, load_in;
   logic [CB-1:0]        idx_ff, idx_in;
   logic [DIM_W-1:0]     row_ff, row_in, col_ff, col_in;
   logic [DIM_W-1:0]     rows_ff, rows_in, cols_ff, cols_in;
   logic [CB-1:0]        last_ff, last_in;
   logic [CB-1:0]        src_ff, src_in, goal_ff, goal_in;
   logic [2:0]           step_ff, step_in;
   logic                 fwd_ff, fwd_in;
   logic                 changed_ff, changed_in;
   logic                 cell_chg_ff, cell_chg_in;
   logic [DIST_W-1:0]    best_ff, best_in;
   logic [COST_BITS-1:0] cost_ff, cost_in;
   logic [29:0]          res_sum_ff, res_sum_in;
   logic                 res_unr_ff, res_unr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [29:0]          rsp_sum_ff, rsp_sum_in;
   logic                 rsp_unr_ff, rsp_unr_in;

   // memories
   logic                 cost_we;
   logic [CB-1:0]        cost_raddr;
   logic [COST_BITS-1:0] cost_rd;
   logic                 dist_we;
   logic [CB-1:0]        dist_waddr, dist_raddr;
   logic [DIST_W-1:0]    dist_wdata, dist_rd;

   gspd_ram #(.WIDTH(COST_BITS), .DEPTH(CELLS)) u_cost_ram (
      .clock   (clock),
      .wr_en   (cost_we),
      .wr_addr (load_ff),
      .wr_data (COST_BITS'(req_tdata)),
      .rd_addr (cost_raddr),
      .rd_data (cost_rd)
   );

   gspd_ram #(.WIDTH(DIST_W), .DEPTH(CELLS)) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_addr (dist_raddr),
      .rd_data (dist_rd)
   );

   // grid dimensions clamped to 1..MAX
   logic [DIM_W-1:0] rows_c, cols_c;
   logic             out_of_grid;
   logic [17:0]      area_c;
   logic [15:0]      src_c, goal_c;

   always_comb begin
      rows_c = {1'b0, num_rows_ff};
      if (rows_c == '0) begin
         rows_c = DIM_W'(1);
      end else if (rows_c > DIM_W'(MAX_ROWS)) begin
         rows_c = DIM_W'(MAX_ROWS);
      end
      cols_c = {1'b0, num_cols_ff};
      if (cols_c == '0) begin
         cols_c = DIM_W'(1);
      end else if (cols_c > DIM_W'(MAX_COLS)) begin
         cols_c = DIM_W'(MAX_COLS);
      end
      out_of_grid = (DIM_W'(start_row_ff) >= rows_c) || (DIM_W'(start_col_ff) >= cols_c)
                 || (DIM_W'(end_row_ff) >= rows_c) || (DIM_W'(end_col_ff) >= cols_c);
      area_c = 18'(rows_c) * 18'(cols_c);
      src_c  = 16'(16'(start_row_ff) * 16'(cols_c)) + 16'(start_col_ff);
      goal_c = 16'(16'(end_row_ff) * 16'(cols_c)) + 16'(end_col_ff);
   end

   // neighbor sources of the current cell: a cell pulls from the cell that moves into it
   logic [CB-1:0] nb_addr [4];
   logic          nb_en   [4];

   always_comb begin
      nb_addr[0] = idx_ff + CB'(1);          // right cell moving left
      nb_addr[1] = idx_ff - CB'(1);          // left cell moving right
      nb_addr[2] = idx_ff + CB'(cols_ff);    // lower cell moving up
      nb_addr[3] = idx_ff - CB'(cols_ff);    // upper cell moving down
      nb_en[0]   = dir_mask_ff[0] && (col_ff + DIM_W'(1) < cols_ff);
      nb_en[1]   = dir_mask_ff[1] && (col_ff != '0);
      nb_en[2]   = dir_mask_ff[2] && (row_ff + DIM_W'(1) < rows_ff);
      nb_en[3]   = dir_mask_ff[3] && (row_ff != '0);
   end

   // shared saturating add and compare
   logic [1:0]        nb_k;
   logic [DIST_W:0]   sum_c;
   logic [DIST_W-1:0] cand_c;
   logic              upd_c;
   logic              pass_end;

   always_comb begin
      nb_k   = 2'(step_ff - 3'd2);
      sum_c  = {1'b0, dist_rd} + (DIST_W + 1)'(cost_ff);
      cand_c = (sum_c > (DIST_W + 1)'(DIST_SAT)) ? DIST_SAT : sum_c[DIST_W-1:0];
      upd_c  = (step_ff >= 3'd2) && nb_en[nb_k] && (dist_rd != DIST_INF)
            && (cand_c < best_ff);
      pass_end = fwd_ff ? (idx_ff == last_ff) : (idx_ff == '0);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_tvalid && req_tuser[0]) state_in = S_SETUP;
         S_SETUP: state_in = out_of_grid ? S_DONE : S_CLEAR;
         S_CLEAR: if (idx_ff == last_ff) state_in = S_INIT0;
         S_INIT0: state_in = S_INIT1;
         S_INIT1: state_in = S_SWEEP;
         S_SWEEP: begin
            if (step_ff == STEP_LAST && pass_end && !(changed_ff || cell_chg_ff || upd_c)) begin
               state_in = S_GOAL0;
            end
         end
         S_GOAL0: state_in = S_GOAL1;
         S_GOAL1: state_in = S_DONE;
         S_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready   = (state_ff == S_IDLE);
      load_in      = load_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      last_in      = last_ff;
      src_in       = src_ff;
      goal_in      = goal_ff;
      step_in      = step_ff;
      fwd_in       = fwd_ff;
      changed_in   = changed_ff;
      cell_chg_in  = cell_chg_ff;
      best_in      = best_ff;
      cost_in      = cost_ff;
      res_sum_in   = res_sum_ff;
      res_unr_in   = res_unr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_unr_in   = rsp_unr_ff;
      cost_we      = 1'b0;
      cost_raddr   = idx_ff;
      dist_we      = 1'b0;
      dist_waddr   = idx_ff;
      dist_wdata   = DIST_INF;
      dist_raddr   = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cost_we = 1'b1;
               load_in = (load_ff == LAST_CELL) ? '0 : load_ff + CB'(1);
               if (req_tuser[0]) begin
                  load_in = '0;
               end
            end
         end
         S_SETUP: begin
            rows_in    = rows_c;
            cols_in    = cols_c;
            last_in    = CB'(area_c - 18'd1);
            src_in     = CB'(src_c);
            goal_in    = CB'(goal_c);
            idx_in     = '0;
            res_sum_in = '0;
            res_unr_in = 1'b1;
         end
         S_CLEAR: begin
            dist_we = 1'b1;
            idx_in  = idx_ff + CB'(1);
         end
         S_INIT0: begin
            cost_raddr = src_ff;
         end
         S_INIT1: begin
            // seed the start cell with its own cost
            dist_we     = 1'b1;
            dist_waddr  = src_ff;
            dist_wdata  = DIST_W'(cost_rd);
            idx_in      = '0;
            row_in      = '0;
            col_in      = '0;
            step_in     = STEP_OWN;
            fwd_in      = 1'b1;
            changed_in  = 1'b0;
            cell_chg_in = 1'b0;
         end
         S_SWEEP: begin
            if (step_ff != STEP_OWN && step_ff != STEP_LAST) begin
               dist_raddr = nb_addr[2'(step_ff - 3'd1)];
            end
            if (step_ff == 3'd1) begin
               best_in = dist_rd;
               cost_in = cost_rd;
            end
            if (upd_c) begin
               best_in     = cand_c;
               cell_chg_in = 1'b1;
            end
            step_in = step_ff + 3'd1;
            if (step_ff == STEP_LAST) begin
               // write back an improved distance and advance to the next cell, or turn at the sweep's end
               dist_we     = cell_chg_ff || upd_c;
               dist_wdata  = upd_c ? cand_c : best_ff;
               step_in     = STEP_OWN;
               cell_chg_in = 1'b0;
               if (pass_end) begin
                  fwd_in     = !fwd_ff;
                  changed_in = 1'b0;
               end else begin
                  changed_in = changed_ff || cell_chg_ff || upd_c;
                  if (fwd_ff) begin
                     idx_in = idx_ff + CB'(1);
                     if (col_ff == cols_ff - DIM_W'(1)) begin
                        col_in = '0;
                        row_in = row_ff + DIM_W'(1);
                     end else begin
                        col_in = col_ff + DIM_W'(1);
                     end
                  end else begin
                     idx_in = idx_ff - CB'(1);
                     if (col_ff == '0) begin
                        col_in = cols_ff - DIM_W'(1);
                        row_in = row_ff - DIM_W'(1);
                     end else begin
                        col_in = col_ff - DIM_W'(1);
                     end
                  end
               end
            end
         end
         S_GOAL0: begin
            dist_raddr = goal_ff;
         end
         S_GOAL1: begin
            res_unr_in = (dist_rd == DIST_INF);
            res_sum_in = (dist_rd == DIST_INF) ? '0 : dist_rd[29:0];
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = res_sum_ff;
               rsp_unr_in   = res_unr_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         load_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ff      <= load_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      rows_ff     <= rows_in;
      cols_ff     <= cols_in;
      last_ff     <= last_in;
      src_ff      <= src_in;
      goal_ff     <= goal_in;
      step_ff     <= step_in;
      fwd_ff      <= fwd_in;
      changed_ff  <= changed_in;
      cell_chg_ff <= cell_chg_in;
      best_ff     <= best_in;
      cost_ff     <= cost_in;
      res_sum_ff  <= res_sum_in;
      res_unr_ff  <= res_unr_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_unr_ff  <= rsp_unr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_sum_ff};
   assign rsp_tuser  = rsp_unr_ff;

endmodule
`default_nettype wire

/* rtl/core/gspd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module gspd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  wire                                       clock,
   input  wire                                       wr_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire [WIDTH-1:0]                           wr_data,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* rtl/core/gspd_checker.sv */
// Port-level checks for the grid shortest path search, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gspd_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire [0:0]  req_tuser,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata,
   input wire [0:0]  rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // an unreachable goal carries a zero sum
   a_unr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("unreachable result with nonzero sum");

   // a last transaction starts the search and drops ready
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] |=> !req_tready)
      else $error("ready after last transaction");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind grid_shortest_path_dijkstra gspd_checker u_gspd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the grid shortest path search block.
`timescale 1ns / 1ps
`default_nettype none

// Tracks the expected search results: mirrors the cell store and registers and
// runs its own Dijkstra search whenever a last cell is accepted.
class PathScoreboard;
   typedef struct {
      logic [29:0] path_sum;
      logic        unreachable;
   } path_result_type;

   localparam int CELLS   = 128 * 128;
   localparam int SUM_MAX = 32'h3FFF_FFFF;
   localparam int NO_DIST = 32'hFFFF_FFFF;

   logic [15:0]     cost_mem[CELLS];
   int unsigned     load_idx;
   logic [7:0]      num_rows, num_cols;
   logic [6:0]      start_row, start_col, end_row, end_col;
   logic [3:0]      dir_mask;
   path_result_type pending[$];
   int unsigned     mismatches;
   int unsigned     results_seen;

   function new();
      load_idx = 0;
      num_rows = 8'd128;
      num_cols = 8'd128;
      start_row = 7'd0;
      start_col = 7'd0;
      end_row = 7'd127;
      end_col = 7'd127;
      dir_mask = 4'hF;
      mismatches = 0;
      results_seen = 0;
      foreach (cost_mem[i]) cost_mem[i] = '0;
   endfunction

   function void set_reg(gspd_pkg::csr_index_type idx, logic [7:0] val);
      case (idx)
         gspd_pkg::CSR_NUM_ROWS:  num_rows = val;
         gspd_pkg::CSR_NUM_COLS:  num_cols = val;
         gspd_pkg::CSR_START_ROW: start_row = val[6:0];
         gspd_pkg::CSR_START_COL: start_col = val[6:0];
         gspd_pkg::CSR_END_ROW:   end_row = val[6:0];
         gspd_pkg::CSR_END_COL:   end_col = val[6:0];
         gspd_pkg::CSR_DIR_MASK:  dir_mask = val[3:0];
         default: ;
      endcase
   endfunction

   static function int unsigned clamp_dim(logic [7:0] v);
      if (v == 0) return 1;
      return (v > 128) ? 128 : v;
   endfunction

   // Plain O(n^2) Dijkstra; the minimum sum does not depend on tie order.
   function path_result_type shortest_path();
      path_result_type res;
      int unsigned rows, cols, n, src, goal, u, best, r, c, nd;
      int unsigned dist_est[];
      bit          done[];
      int unsigned nbr[4];
      bit          ok[4];
      rows = clamp_dim(num_rows);
      cols = clamp_dim(num_cols);
      res.path_sum = '0;
      res.unreachable = 1'b1;
      if (start_row >= rows || start_col >= cols || end_row >= rows || end_col >= cols)
         return res;
      n = rows * cols;
      dist_est = new[n];
      done = new[n];
      foreach (dist_est[i]) begin
         dist_est[i] = NO_DIST;
         done[i] = 0;
      end
      src = start_row * cols + start_col;
      goal = end_row * cols + end_col;
      dist_est[src] = cost_mem[src];
      forever begin
         best = NO_DIST;
         u = 0;
         for (int i = 0; i < n; i++)
            if (!done[i] && dist_est[i] < best) begin
               best = dist_est[i];
               u = i;
            end
         if (best == NO_DIST) return res;
         done[u] = 1;
         if (u == goal) begin
            res.path_sum = dist_est[u][29:0];
            res.unreachable = 1'b0;
            return res;
         end
         r = u / cols;
         c = u % cols;
         ok[0] = dir_mask[0] && c > 0;          nbr[0] = u - 1;
         ok[1] = dir_mask[1] && c + 1 < cols;   nbr[1] = u + 1;
         ok[2] = dir_mask[2] && r > 0;          nbr[2] = u - cols;
         ok[3] = dir_mask[3] && r + 1 < rows;   nbr[3] = u + cols;
         for (int k = 0; k < 4; k++)
            if (ok[k] && !done[nbr[k]]) begin
               nd = (dist_est[u] + cost_mem[nbr[k]] > SUM_MAX) ? SUM_MAX
                                                               : dist_est[u] + cost_mem[nbr[k]];
               if (nd < dist_est[nbr[k]]) dist_est[nbr[k]] = nd;
            end
      end
   endfunction

   // Store an accepted cell; a last cell launches the search.
   function void note_cell(logic [15:0] cost, logic last);
      cost_mem[load_idx] = cost;
      load_idx = (load_idx + 1) % CELLS;
      if (last) begin
         load_idx = 0;
         pending.insert(pending.size(), shortest_path());
      end
   endfunction

   task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task check_result(logic [31:0] tdata, logic [0:0] tuser);
      path_result_type want;
      results_seen++;
      if (pending.size() == 0) begin
         report_mismatch($sformatf("unexpected result sum=%0d unreachable=%0b", tdata, tuser));
         return;
      end
      want = pending.pop_front();
      if (tdata !== {2'b00, want.path_sum})
         report_mismatch($sformatf("path_sum got %0d want %0d", tdata, want.path_sum));
      if (tuser[0] !== want.unreachable)
         report_mismatch($sformatf("unreachable got %0b want %0b", tuser, want.unreachable));
   endtask
endclass

module tb_top;
   import gspd_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int ITEM_TARGET = 700;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // cell_cost[15:0]
   logic [0:0]  req_tuser;   // last
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // path_sum[29:0], zero fill
   logic [0:0]  rsp_tuser;   // unreachable
   logic        csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   PathScoreboard sb;
   int unsigned   cells_accepted;
   int unsigned   grids_sent;
   int unsigned   cycle_count;
   int unsigned   random_base;     // cells taken before the random phases
   int unsigned   send_idle_pct;   // chance per cycle that the sender holds off
   int unsigned   recv_stall_pct;  // chance per cycle that the receiver stalls

   grid_shortest_path_dijkstra u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Grid dimension as the block sees it: zero counts as one, saturate at 128.
   function automatic int unsigned grid_dim(logic [7:0] v);
      if (v == 0) return 1;
      return (v > 128) ? 128 : v;
   endfunction

   // Watchdog: abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // Sample both channels at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (sb != null && reset === 1'b0) begin
         if (req_tvalid && req_tready) begin
            sb.note_cell(req_tdata, req_tuser[0]);
            cells_accepted++;
         end
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Receiver back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      if (reset === 1'b0)
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Hold until every expected result has come, then let the block settle.
   task automatic wait_drained();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Write all seven registers; the block is idle here.
   task automatic load_regs(logic [7:0] rows, logic [7:0] cols, logic [6:0] sr,
                            logic [6:0] sc, logic [6:0] er, logic [6:0] ec,
                            logic [3:0] mask);
      logic [7:0] vals[7];
      vals = '{rows, cols, {1'b0, sr}, {1'b0, sc}, {1'b0, er}, {1'b0, ec}, {4'h0, mask}};
      for (int i = 0; i < 7; i++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_addr <= csr_index_type'(i);
         csr_wdata <= vals[i];
         sb.set_reg(csr_index_type'(i), vals[i]);
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Offer one cell and hold it until the block takes it.
   task automatic send_cell(logic [15:0] cost, logic last);
      int unsigned target;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      target = cells_accepted + 1;
      req_tvalid <= 1'b1;
      req_tdata <= cost;
      req_tuser <= last;
      do @(negedge clock); while (cells_accepted < target);
   endtask

   function automatic logic [15:0] pick_cost(int unsigned mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(9));
         2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom_range(255));
      endcase
   endfunction

   // Configure, then stream one full grid; the last cell starts the search.
   task automatic run_grid(logic [7:0] rows, logic [7:0] cols, logic [6:0] sr,
                           logic [6:0] sc, logic [6:0] er, logic [6:0] ec,
                           logic [3:0] mask, int unsigned mode);
      int unsigned n;
      wait_drained();
      load_regs(rows, cols, sr, sc, er, ec, mask);
      n = grid_dim(rows) * grid_dim(cols);
      for (int i = 0; i < n; i++)
         send_cell(pick_cost(mode), i == n - 1);
      req_tvalid <= 1'b0;
      grids_sent++;
   endtask

   task automatic random_grid();
      logic [7:0] rows, cols;
      logic [6:0] sr, sc, er, ec;
      logic [3:0] mask;
      if ($urandom_range(9) == 0) begin
         // long strip, one dimension at 1
         rows = 8'd1;
         cols = 8'($urandom_range(40, 20));
         if ($urandom_range(1)) begin
            rows = cols;
            cols = 8'd1;
         end
      end else begin
         rows = 8'($urandom_range(6, 1));
         cols = 8'($urandom_range(6, 1));
      end
      sr = 7'($urandom_range(grid_dim(rows) - 1));
      sc = 7'($urandom_range(grid_dim(cols) - 1));
      er = 7'($urandom_range(grid_dim(rows) - 1));
      ec = 7'($urandom_range(grid_dim(cols) - 1));
      if ($urandom_range(19) == 0) er = 7'($urandom_range(127));
      if ($urandom_range(19) == 0) sc = 7'($urandom_range(127));
      mask = ($urandom_range(3) == 0) ? 4'($urandom) : 4'hF;
      run_grid(rows, cols, sr, sc, er, ec, mask, $urandom_range(3));
   endtask

   initial begin
      sb = new();
      cells_accepted = 0;
      grids_sent = 0;
      cycle_count = 0;
      random_base = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      rsp_tready <= 1'b0;
      csr_we <= 1'b0;
      csr_addr <= CSR_NUM_ROWS;
      csr_wdata <= '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed: zero dimensions count as one, start equals goal, cost at the top or zero.
      run_grid(8'd0, 8'd0, 7'd0, 7'd0, 7'd0, 7'd0, 4'hF, 2);
      // no moves allowed: goal unreachable
      run_grid(8'd2, 8'd2, 7'd0, 7'd0, 7'd1, 7'd1, 4'h0, 0);
      // start, then goal, outside the grid, at the top of its range
      run_grid(8'd2, 8'd3, 7'd127, 7'd0, 7'd1, 7'd1, 4'hF, 1);
      run_grid(8'd3, 8'd2, 7'd0, 7'd0, 7'd1, 7'd127, 4'hF, 1);
      // oversized row count saturates; walk down the full column
      run_grid(8'd255, 8'd1, 7'd0, 7'd0, 7'd127, 7'd0, 4'h8, 0);
      // full-width row, right moves only, costs at the top or zero
      run_grid(8'd1, 8'd128, 7'd0, 7'd0, 7'd0, 7'd127, 4'h2, 2);
      // left only from the far end; then the wrong way round
      run_grid(8'd1, 8'd255, 7'd0, 7'd127, 7'd0, 7'd0, 4'h1, 3);
      run_grid(8'd1, 8'd5, 7'd0, 7'd0, 7'd0, 7'd4, 4'h1, 3);
      // up only; then all directions with costs at the top or zero
      run_grid(8'd3, 8'd3, 7'd2, 7'd1, 7'd0, 7'd1, 4'h4, 1);
      run_grid(8'd4, 8'd4, 7'd3, 7'd3, 7'd0, 7'd0, 4'hF, 2);

      // Random phases with different idling on each side share what is left.
      random_base = cells_accepted;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         while (random_base < ITEM_TARGET &&
                cells_accepted < random_base + (ITEM_TARGET - random_base) * (ph + 1) / 4)
            random_grid();
      end

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("covered %0d grids (%0d cells), %0d results checked",
               grids_sent, cells_accepted, sb.results_seen);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/gspd_pkg.sv
rtl/core/gspd_ram.sv
rtl/core/grid_shortest_path_dijkstra.sv
rtl/core/gspd_checker.sv
bench/tb_top.sv
